// ===== design/elfbid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package elfbid_pkg;

  // Default store depth in bytes.
  localparam int unsigned MAX_IMAGE_BYTES_DEF = 65536;

  // FNV-1a 64: the prime is 2^40 + 0x1b3.
  localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
  localparam logic [8:0]  FNV_PRIME_LO    = 9'h1b3;
  localparam int unsigned FNV_PRIME_SHIFT = 40;

  // ELF constants.
  localparam logic [63:0] ELF_HDR_BYTES   = 64'd64;
  localparam logic [15:0] SH_ENT_BYTES    = 16'd64;
  localparam logic [31:0] SHT_NOTE        = 32'd7;
  localparam logic [31:0] NT_GNU_BUILD_ID = 32'd3;
  localparam logic [63:0] NOTE_MIN_BYTES  = 64'd16;
  localparam logic [63:0] NOTE_HDR_BYTES  = 64'd12;
  localparam logic [63:0] DESC_MIN_BYTES  = 64'd8;

  // Bytes of ".note.gnu.build-id" with its terminating zero.
  function automatic logic [7:0] target_byte(input logic [4:0] k);
    logic [7:0] b;
    unique case (k)
      5'd0:  b = 8'h2e;
      5'd1:  b = 8'h6e;
      5'd2:  b = 8'h6f;
      5'd3:  b = 8'h74;
      5'd4:  b = 8'h65;
      5'd5:  b = 8'h2e;
      5'd6:  b = 8'h67;
      5'd7:  b = 8'h6e;
      5'd8:  b = 8'h75;
      5'd9:  b = 8'h2e;
      5'd10: b = 8'h62;
      5'd11: b = 8'h75;
      5'd12: b = 8'h69;
      5'd13: b = 8'h6c;
      5'd14: b = 8'h64;
      5'd15: b = 8'h2d;
      5'd16: b = 8'h69;
      5'd17: b = 8'h64;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== design/elf_build_id_fingerprint_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Image bytes load and hash at one item per cycle into a byte store while in_ready is high (load state only).
// After the last byte the section walk gathers each field little-endian from the store:
// first for the header checks, then each section header, each name byte compared and
// the build-id note, and finally the result is handed off.
// Oversized and too-short images skip the section walk and go straight to the hand-off.
// Synchronous active-low reset clears control, count and hash; the store is not cleared.

module elf_build_id_fingerprint_top #(
  parameter int unsigned MAX_IMAGE_BYTES = elfbid_pkg::MAX_IMAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [63:0] out_fingerprint,
  output logic             out_from_build_id,
  output logic             out_image_overflow
);

  localparam int unsigned AW = $clog2(MAX_IMAGE_BYTES);
  localparam int unsigned CW = $clog2(MAX_IMAGE_BYTES + 2);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EVAL  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef enum logic [13:0] {
    P_MAGIC   = 14'b00000000000001,
    P_SHOFF   = 14'b00000000000010,
    P_SHINFO  = 14'b00000000000100,
    P_STROFF  = 14'b00000000001000,
    P_STRSIZE = 14'b00000000010000,
    P_SECGO   = 14'b00000000100000,
    P_SECHDR  = 14'b00000001000000,
    P_NAMEGO  = 14'b00000010000000,
    P_NAME    = 14'b00000100000000,
    P_SECOFF  = 14'b00001000000000,
    P_SECSIZE = 14'b00010000000000,
    P_NOTEHDR = 14'b00100000000000,
    P_NTYPE   = 14'b01000000000000,
    P_DESC    = 14'b10000000000000
  } step_t;

  logic [7:0] store_mem [MAX_IMAGE_BYTES];
  logic [7:0] rdata_r;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [AW-1:0] fb_r, fb_nxt;
  logic [3:0] fn_r, fn_nxt, fk_r, fk_nxt;
  logic cap_v_r, cap_v_nxt;
  logic [2:0] cap_k_r, cap_k_nxt;
  logic [63:0] sto_r, sto_nxt, nto_r, nto_nxt, nts_r, nts_nxt;
  logic [63:0] off_r, off_nxt, size_r, size_nxt;
  logic [15:0] cnt_r, cnt_nxt, strx_r, strx_nxt, sec_r, sec_nxt;
  logic [31:0] name_r, name_nxt, namesz_r, namesz_nxt, descsz_r, descsz_nxt;
  logic [4:0] k_r, k_nxt;
  logic [63:0] id_r, id_nxt;
  logic found_r, found_nxt, ovf_r, ovf_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [63:0] out_fp_r, out_fp_nxt;
  logic out_bid_r, out_bid_nxt, out_ovf_r, out_ovf_nxt;

  logic in_acc;
  logic [63:0] hash;
  logic hash_clr;
  logic [AW-1:0] rd_addr;
  logic [63:0] len64;
  logic [15:0] sh_idx;
  logic [63:0] sh_sum;
  logic [AW-1:0] sh_base;
  logic [63:0] pos64;
  logic [63:0] aligned;
  logic [63:0] body;
  logic [63:0] desc_sum;
  logic [7:0] tgt;

  logic fetch_go;
  logic [AW-1:0] fetch_base;
  logic [3:0] fetch_n;
  step_t fetch_step;

  assign in_ready = (state_r == S_LOAD);
  assign in_acc = in_valid && in_ready;
  assign len64 = 64'(count_r);

  elfbid_fnv u_fnv (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (in_acc),
    .clr     (hash_clr),
    .byte_in (in_byte_value),
    .hash    (hash)
  );

  // Byte store: writes during load, reads for the section walk.
  assign rd_addr = fb_r + AW'(fk_r);
  always_ff @(posedge clk) begin
    if (in_acc && (count_r < CW'(MAX_IMAGE_BYTES))) begin
      store_mem[count_r[AW-1:0]] <= in_byte_value;
    end
    rdata_r <= store_mem[rd_addr];
  end

  // Section header address for the index in use by the current step, plus name, note and descriptor offsets.
  always_comb begin
    priority case (1'b1)
      step_r == P_SHINFO: sh_idx = acc_r[47:32];
      step_r == P_STROFF: sh_idx = strx_r;
      default:            sh_idx = sec_r;
    endcase
    sh_sum  = sto_r + {42'd0, sh_idx, 6'd0};
    sh_base = sh_sum[AW-1:0];
    pos64   = nto_r + {32'd0, name_r} + {59'd0, k_r};
    aligned = ({32'd0, namesz_r} + 64'd3) & ~64'd3;
    body    = size_r - elfbid_pkg::NOTE_HDR_BYTES;
    desc_sum = off_r + elfbid_pkg::NOTE_HDR_BYTES + aligned;
    tgt     = elfbid_pkg::target_byte(k_r);
  end

  // Parse sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    count_nxt = count_r;
    acc_nxt = acc_r;
    fb_nxt = fb_r;
    fn_nxt = fn_r;
    fk_nxt = fk_r;
    cap_v_nxt = 1'b0;
    cap_k_nxt = cap_k_r;
    sto_nxt = sto_r;
    nto_nxt = nto_r;
    nts_nxt = nts_r;
    off_nxt = off_r;
    size_nxt = size_r;
    cnt_nxt = cnt_r;
    strx_nxt = strx_r;
    sec_nxt = sec_r;
    name_nxt = name_r;
    namesz_nxt = namesz_r;
    descsz_nxt = descsz_r;
    k_nxt = k_r;
    id_nxt = id_r;
    found_nxt = found_r;
    ovf_nxt = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_fp_nxt = out_fp_r;
    out_bid_nxt = out_bid_r;
    out_ovf_nxt = out_ovf_r;
    hash_clr = 1'b0;
    fetch_go = 1'b0;
    fetch_base = '0;
    fetch_n = 4'd8;
    fetch_step = step_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (count_r <= CW'(MAX_IMAGE_BYTES)) begin
            count_nxt = count_r + CW'(1);
          end
          if (in_last_byte) begin
            found_nxt = 1'b0;
            sec_nxt = '0;
            ovf_nxt = (count_nxt > CW'(MAX_IMAGE_BYTES));
            if (ovf_nxt || (64'(count_nxt) < elfbid_pkg::ELF_HDR_BYTES)) begin
              state_nxt = S_DONE;
            end else begin
              fetch_go = 1'b1;
              fetch_base = '0;
              fetch_n = 4'd5;
              fetch_step = P_MAGIC;
            end
          end
        end
      end
      S_FETCH: begin
        if (fk_r < fn_r) begin
          fk_nxt = fk_r + 4'd1;
          cap_v_nxt = 1'b1;
          cap_k_nxt = fk_r[2:0];
        end
        if (cap_v_r) begin
          acc_nxt[8*cap_k_r +: 8] = rdata_r;
          if ({1'b0, cap_k_r} == (fn_r - 4'd1)) begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        unique case (step_r)
          P_MAGIC: begin
            if (acc_r[39:0] == 40'h02464c457f) begin
              fetch_go = 1'b1;
              fetch_base = AW'(40);
              fetch_step = P_SHOFF;
            end
          end
          P_SHOFF: begin
            sto_nxt = acc_r;
            fetch_go = 1'b1;
            fetch_base = AW'(58);
            fetch_n = 4'd6;
            fetch_step = P_SHINFO;
          end
          P_SHINFO: begin
            cnt_nxt = acc_r[31:16];
            strx_nxt = acc_r[47:32];
            if ((acc_r[15:0] == elfbid_pkg::SH_ENT_BYTES) && (sto_r <= len64) &&
                ({42'd0, acc_r[31:16], 6'd0} <= (len64 - sto_r)) &&
                (acc_r[47:32] < acc_r[31:16])) begin
              fetch_go = 1'b1;
              fetch_base = sh_base + AW'(24);
              fetch_step = P_STROFF;
            end
          end
          P_STROFF: begin
            nto_nxt = acc_r;
            fetch_go = 1'b1;
            fetch_base = sh_base + AW'(32);
            fetch_step = P_STRSIZE;
          end
          P_STRSIZE: begin
            nts_nxt = acc_r;
            if ((nto_r <= len64) && (acc_r <= (len64 - nto_r))) begin
              state_nxt = S_EVAL;
              step_nxt = P_SECGO;
            end
          end
          P_SECGO: begin
            if (sec_r < cnt_r) begin
              fetch_go = 1'b1;
              fetch_base = sh_base;
              fetch_step = P_SECHDR;
            end
          end
          P_SECHDR: begin
            name_nxt = acc_r[31:0];
            k_nxt = '0;
            state_nxt = S_EVAL;
            if ((acc_r[63:32] == elfbid_pkg::SHT_NOTE) && ({32'd0, acc_r[31:0]} < nts_r)) begin
              step_nxt = P_NAMEGO;
            end else begin
              sec_nxt = sec_r + 16'd1;
              step_nxt = P_SECGO;
            end
          end
          P_NAMEGO: begin
            if (pos64 >= len64) begin
              sec_nxt = sec_r + 16'd1;
              state_nxt = S_EVAL;
              step_nxt = P_SECGO;
            end else begin
              fetch_go = 1'b1;
              fetch_base = pos64[AW-1:0];
              fetch_n = 4'd1;
              fetch_step = P_NAME;
            end
          end
          P_NAME: begin
            if (acc_r[7:0] != tgt) begin
              sec_nxt = sec_r + 16'd1;
              state_nxt = S_EVAL;
              step_nxt = P_SECGO;
            end else if (tgt == 8'h00) begin
              fetch_go = 1'b1;
              fetch_base = sh_base + AW'(24);
              fetch_step = P_SECOFF;
            end else begin
              k_nxt = k_r + 5'd1;
              state_nxt = S_EVAL;
              step_nxt = P_NAMEGO;
            end
          end
          P_SECOFF: begin
            off_nxt = acc_r;
            fetch_go = 1'b1;
            fetch_base = sh_base + AW'(32);
            fetch_step = P_SECSIZE;
          end
          P_SECSIZE: begin
            size_nxt = acc_r;
            if ((acc_r >= elfbid_pkg::NOTE_MIN_BYTES) && (off_r <= len64) &&
                (acc_r <= (len64 - off_r))) begin
              fetch_go = 1'b1;
              fetch_base = off_r[AW-1:0];
              fetch_step = P_NOTEHDR;
            end
          end
          P_NOTEHDR: begin
            namesz_nxt = acc_r[31:0];
            descsz_nxt = acc_r[63:32];
            fetch_go = 1'b1;
            fetch_base = off_r[AW-1:0] + AW'(8);
            fetch_n = 4'd4;
            fetch_step = P_NTYPE;
          end
          P_NTYPE: begin
            if ((acc_r[31:0] == elfbid_pkg::NT_GNU_BUILD_ID) &&
                ({32'd0, descsz_r} >= elfbid_pkg::DESC_MIN_BYTES) &&
                ({32'd0, namesz_r} <= size_r) && (aligned <= body) &&
                ((body - aligned) >= elfbid_pkg::DESC_MIN_BYTES)) begin
              fetch_go = 1'b1;
              fetch_base = desc_sum[AW-1:0];
              fetch_step = P_DESC;
            end
          end
          P_DESC: begin
            found_nxt = 1'b1;
            id_nxt = acc_r;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        // Hand the result to the output register and rearm for the next image.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_fp_nxt = found_r ? id_r : hash;
          out_bid_nxt = found_r;
          out_ovf_nxt = ovf_r;
          count_nxt = '0;
          hash_clr = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // Start a little-endian gather of fetch_n bytes.
    if (fetch_go) begin
      state_nxt = S_FETCH;
      step_nxt = fetch_step;
      fb_nxt = fetch_base;
      fn_nxt = fetch_n;
      fk_nxt = '0;
      acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      step_r <= P_MAGIC;
      count_r <= '0;
      cap_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      count_r <= count_nxt;
      cap_v_r <= cap_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    fb_r <= fb_nxt;
    fn_r <= fn_nxt;
    fk_r <= fk_nxt;
    cap_k_r <= cap_k_nxt;
    sto_r <= sto_nxt;
    nto_r <= nto_nxt;
    nts_r <= nts_nxt;
    off_r <= off_nxt;
    size_r <= size_nxt;
    cnt_r <= cnt_nxt;
    strx_r <= strx_nxt;
    sec_r <= sec_nxt;
    name_r <= name_nxt;
    namesz_r <= namesz_nxt;
    descsz_r <= descsz_nxt;
    k_r <= k_nxt;
    id_r <= id_nxt;
    found_r <= found_nxt;
    ovf_r <= ovf_nxt;
    out_fp_r <= out_fp_nxt;
    out_bid_r <= out_bid_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_fingerprint = out_fp_r;
  assign out_from_build_id = out_bid_r;
  assign out_image_overflow = out_ovf_r;

endmodule

`default_nettype wire

// ===== design/elfbid_fnv.sv =====
`timescale 1ns / 1ps
`default_nettype none

module elfbid_fnv (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        upd,
  input  wire logic        clr,
  input  wire logic [7:0]  byte_in,
  output logic      [63:0] hash
);

  logic [63:0] hash_r;
  logic [63:0] hash_nxt;
  logic [63:0] mix;

  // One FNV-1a round: xor the byte in, then multiply by the prime as a shift plus a
  // narrow product.
  always_comb begin
    mix = hash_r ^ {56'd0, byte_in};
    hash_nxt = hash_r;
    if (clr) begin
      hash_nxt = elfbid_pkg::FNV_BASIS;
    end else if (upd) begin
      hash_nxt = (mix << elfbid_pkg::FNV_PRIME_SHIFT) + (mix * {55'd0, elfbid_pkg::FNV_PRIME_LO});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= elfbid_pkg::FNV_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  assign hash = hash_r;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned STORE_BYTES = elfbid_pkg::MAX_IMAGE_BYTES_DEF;
  localparam int unsigned IDLE_LIMIT  = 400000;
  localparam string       BID_NAME    = ".note.gnu.build-id";

  typedef struct packed {
    logic [63:0] fingerprint;
    logic        from_build_id;
    logic        image_overflow;
  } fp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_fingerprint;
  logic        out_from_build_id;
  logic        out_image_overflow;

  // Mirror of the image store, needed because the parse works on the stored bytes.
  logic [7:0]  store_mirror [0:STORE_BYTES-1];
  fp_result_t  pending_fp [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          hold_off_cycles = 0;
  bit          gaps_on = 1'b1;
  int          items_sent = 0;
  int          results_seen = 0;

  elf_build_id_fingerprint_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_value     (in_byte_value),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fingerprint   (out_fingerprint),
    .out_from_build_id (out_from_build_id),
    .out_image_overflow(out_image_overflow)
  );

  always #5 clk = ~clk;

  // Little-endian read of the mirrored store; addresses past the store read as zero.
  function automatic logic [63:0] mirror_le(input logic [63:0] off, input int n);
    logic [63:0] v;
    logic [63:0] idx;
    v = '0;
    for (int k = 0; k < n; k++) begin
      idx = off + k;
      if (idx < STORE_BYTES) v |= 64'(store_mirror[idx]) << (8 * k);
    end
    return v;
  endfunction

  function automatic logic [7:0] bid_name_byte(input int k);
    return (k < 18) ? 8'(BID_NAME[k]) : 8'h00;
  endfunction

  // Header checks and section walk; returns 1 with the build id when one is found.
  function automatic bit search_build_id(input logic [63:0] len, output logic [63:0] bid);
    logic [63:0] shoff, entsize, shnum, strndx, sh, str_off, str_size;
    logic [63:0] nm, sh_type, noff, nsize, namesz, descsz, ntype, aligned, pos;
    bit          hit;
    bid = '0;
    if (len < 64) return 1'b0;
    if (store_mirror[0] != 8'h7f || store_mirror[1] != 8'h45 || store_mirror[2] != 8'h4c ||
        store_mirror[3] != 8'h46 || store_mirror[4] != 8'h02) return 1'b0;
    shoff   = mirror_le(40, 8);
    entsize = mirror_le(58, 2);
    shnum   = mirror_le(60, 2);
    strndx  = mirror_le(62, 2);
    if (entsize != 64 || shoff > len || entsize * shnum > len - shoff || strndx >= shnum)
      return 1'b0;
    sh       = shoff + 64 * strndx;
    str_off  = mirror_le(sh + 24, 8);
    str_size = mirror_le(sh + 32, 8);
    if (str_off > len || str_size > len - str_off) return 1'b0;
    for (logic [63:0] i = 0; i < shnum; i++) begin
      sh      = shoff + 64 * i;
      nm      = mirror_le(sh, 4);
      sh_type = mirror_le(sh + 4, 4);
      noff    = mirror_le(sh + 24, 8);
      nsize   = mirror_le(sh + 32, 8);
      if (sh_type != 7 || nm >= str_size) continue;
      hit = 1'b1;
      for (int k = 0; k < 19; k++) begin
        pos = str_off + nm + k;
        if (pos >= len || store_mirror[pos] != bid_name_byte(k)) begin
          hit = 1'b0;
          break;
        end
        if (bid_name_byte(k) == 8'h00) break;
      end
      if (!hit) continue;
      // The first matching note section decides the outcome.
      if (nsize < 16 || noff > len || nsize > len - noff) return 1'b0;
      namesz = mirror_le(noff, 4);
      descsz = mirror_le(noff + 4, 4);
      ntype  = mirror_le(noff + 8, 4);
      if (ntype != 3 || descsz < 8 || namesz > nsize) return 1'b0;
      aligned = (namesz + 3) & ~64'd3;
      if (aligned > nsize - 12 || nsize - 12 - aligned < 8) return 1'b0;
      bid = mirror_le(noff + 12 + aligned, 8);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Expected fingerprint of one whole image.
  function automatic fp_result_t fingerprint_of(ref logic [7:0] img [$]);
    fp_result_t  r;
    logic [63:0] h, bid;
    h = elfbid_pkg::FNV_BASIS;
    foreach (img[i]) begin
      if (i < STORE_BYTES) store_mirror[i] = img[i];
      h = (h ^ 64'(img[i])) * 64'h100000001b3;
    end
    r.image_overflow = (img.size() > STORE_BYTES);
    r.from_build_id  = 1'b0;
    r.fingerprint    = h;
    if (!r.image_overflow && search_build_id(64'(img.size()), bid)) begin
      r.from_build_id = 1'b1;
      r.fingerprint   = bid;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Offer one item; called and returns at a rising edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_last_byte  <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // The sender deasserts in_valid after each image.
  task automatic send_image(ref logic [7:0] img [$]);
    pending_fp.push_back(fingerprint_of(img));
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (pending_fp.size() != 0) @(posedge clk);
  endtask

  task automatic put_le(ref logic [7:0] img [$], input int off, input logic [63:0] v,
                        input int n);
    for (int k = 0; k < n; k++) img[off + k] = v[8*k +: 8];
  endtask

  // Well-formed ELF: string table at 64, build-id note at 96, section table after it.
  task automatic make_elf(ref logic [7:0] img [$], input int nsec, input int bid_sec,
                          output int shoff);
    string strs;
    int    descsz, note_sz, sec;
    strs   = {"#", BID_NAME, "#.text#"};
    descsz = 8 + 4 * $urandom_range(0, 2);
    note_sz = 16 + descsz;
    shoff  = (96 + note_sz + 7) & ~7;
    img.delete();
    for (int i = 0; i < shoff + 64 * nsec; i++) img.push_back(8'($urandom()));
    for (int i = 0; i < 64; i++) img[i] = 8'h00;
    put_le(img, 0, 64'h02464c457f, 5);
    put_le(img, 40, shoff, 8);
    put_le(img, 58, 64, 2);
    put_le(img, 60, nsec, 2);
    put_le(img, 62, 0, 2);
    for (int i = 0; i < strs.len(); i++) img[64 + i] = (strs[i] == "#") ? 8'h00 : 8'(strs[i]);
    put_le(img, 96, 4, 4);
    put_le(img, 100, descsz, 4);
    put_le(img, 104, 3, 4);
    put_le(img, 108, 64'h00554e47, 4);
    for (int s = 0; s < nsec; s++) begin
      sec = shoff + 64 * s;
      for (int i = 0; i < 64; i++) img[sec + i] = 8'h00;
      if (s == 0) begin
        put_le(img, sec + 4, 3, 4);
        put_le(img, sec + 24, 64, 8);
        put_le(img, sec + 32, strs.len(), 8);
      end else if (s == bid_sec) begin
        put_le(img, sec, 1, 4);
        put_le(img, sec + 4, 7, 4);
        put_le(img, sec + 24, 96, 8);
        put_le(img, sec + 32, note_sz, 8);
      end else begin
        put_le(img, sec, ($urandom_range(0, 1) != 0) ? 20 : 1, 4);
        put_le(img, sec + 4, ($urandom_range(0, 1) != 0) ? 7 : 1, 4);
        put_le(img, sec + 24, 64'($urandom_range(0, 200)), 8);
        put_le(img, sec + 32, 64'($urandom_range(0, 40)), 8);
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int len;
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      len = $urandom_range(0, 99);
      len = (len < 70) ? $urandom_range(1, 3) : (len < 95) ? $urandom_range(4, 10)
                                              : $urandom_range(30, 120);
      out_ready <= ($urandom_range(0, 2) != 0);
      repeat (len) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    fp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_fp.size() == 0) begin
        $error("result with no expectation waiting: fingerprint %h", out_fingerprint);
        fail_count++;
      end else begin
        want = pending_fp.pop_front();
        if (out_fingerprint !== want.fingerprint) begin
          $error("fingerprint: expected %h actual %h", want.fingerprint, out_fingerprint);
          fail_count++;
        end
        if (out_from_build_id !== want.from_build_id) begin
          $error("from_build_id: expected %b actual %b", want.from_build_id,
                 out_from_build_id);
          fail_count++;
        end
        if (out_image_overflow !== want.image_overflow) begin
          $error("image_overflow: expected %b actual %b", want.image_overflow,
                 out_image_overflow);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item or result.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL elf_build_id_fingerprint_top");
      $finish;
    end
  end

  // Extreme bytes and headers that fail early.
  task automatic test_short_images();
    logic [7:0] img [$];
    img = '{8'h00};
    send_image(img);
    img = '{8'hff};
    send_image(img);
    img.delete();
    for (int i = 0; i < 63; i++) img.push_back(8'($urandom()));
    put_le(img, 0, 64'h02464c457f, 5);
    send_image(img);
    img.push_back(8'hff);
    send_image(img);
    img[4] = 8'h01;
    send_image(img);
    img[0] = 8'h7e;
    send_image(img);
  endtask

  // Valid build ids and the named failure cases.
  task automatic test_elf_cases();
    logic [7:0] img [$];
    int shoff;
    make_elf(img, 3, 1, shoff);
    send_image(img);
    make_elf(img, 4, 3, shoff);
    send_image(img);
    // Matching note with a wrong note type.
    make_elf(img, 2, 1, shoff);
    put_le(img, 104, 5, 4);
    send_image(img);
    // Wrong section entry size.
    make_elf(img, 2, 1, shoff);
    put_le(img, 58, 32, 2);
    send_image(img);
    // String table index out of range.
    make_elf(img, 2, 1, shoff);
    put_le(img, 62, 2, 2);
    send_image(img);
    // Odd name size needs alignment; the descriptor then fits only when descsz is 16.
    make_elf(img, 2, 1, shoff);
    put_le(img, 96, 9, 4);
    send_image(img);
    // Short note section.
    make_elf(img, 2, 1, shoff);
    put_le(img, shoff + 64 + 32, 12, 8);
    send_image(img);
    // First matching section has a bad note, a later one is good: hash wins.
    make_elf(img, 3, 2, shoff);
    put_le(img, shoff + 64, 1, 4);
    put_le(img, shoff + 64 + 4, 7, 4);
    put_le(img, shoff + 64 + 24, 0, 8);
    put_le(img, shoff + 64 + 32, 8, 8);
    send_image(img);
    // Name that runs to the end of the image: the compare stops there.
    make_elf(img, 2, 1, shoff);
    for (int i = 0; i < 5; i++) img.push_back(8'(BID_NAME[i]));
    put_le(img, shoff + 32, img.size() - 64, 8);
    put_le(img, shoff + 64, img.size() - 5 - 64, 4);
    send_image(img);
    wait_drain();
  endtask

  // A full store and one byte more.
  task automatic test_store_limit();
    logic [7:0] img [$];
    gaps_on = 1'b0;
    for (int i = 0; i < STORE_BYTES; i++) img.push_back(8'($urandom()));
    put_le(img, 0, 64'h02464c457f, 5);
    send_image(img);
    img.push_back(8'($urandom()));
    send_image(img);
    gaps_on = 1'b1;
    wait_drain();
  endtask

  // Receiver holds off while images keep coming; then the sender waits for all results.
  task automatic test_back_pressure();
    logic [7:0] img [$];
    int shoff;
    hold_off_cycles = 500;
    for (int n = 0; n < 4; n++) begin
      make_elf(img, 2, 1, shoff);
      send_image(img);
    end
    wait_drain();
  endtask

  task automatic test_random_images();
    logic [7:0] img [$];
    int shoff, nsec, roll, len;
    while (items_sent < 1300 + STORE_BYTES * 2 + 2000 || results_seen < 60) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        nsec = $urandom_range(2, 4);
        make_elf(img, nsec, $urandom_range(1, nsec - 1), shoff);
        if ($urandom_range(0, 99) < 45) begin
          repeat ($urandom_range(1, 3))
            img[$urandom_range(0, img.size() - 1)] = 8'($urandom());
        end
        if ($urandom_range(0, 99) < 10) img = img[0:$urandom_range(0, img.size() - 1)];
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 12);
        img.delete();
        for (int i = 0; i < len; i++) img.push_back(8'($urandom()));
        if (len >= 5 && $urandom_range(0, 1) != 0) put_le(img, 0, 64'h02464c457f, 5);
      end
      send_image(img);
    end
    wait_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_images();
    test_elf_cases();
    test_store_limit();
    test_back_pressure();
    test_random_images();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_fp.size() == 0) begin
      $display("PASS elf_build_id_fingerprint_top");
    end else begin
      $display("FAIL elf_build_id_fingerprint_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/elfbid_pkg.sv
design/elfbid_fnv.sv
design/elf_build_id_fingerprint_top.sv
test/tb_top.sv
